// ----- rtl/bbp_pkg.sv -----
// Shared types and constants for the two-level branch predictor.
// No dependencies; imported by every module of the block but bbp_ram.
`default_nettype none
package bbp_pkg;

  localparam int BTB_DEPTH   = 32;
  localparam int SLOT_W      = 5;
  localparam int MAX_HISTORY = 8;
  localparam int MAX_TAG     = 30;
  localparam int ROW_LEN     = 1 << MAX_HISTORY;
  localparam int CTR_DEPTH   = BTB_DEPTH * ROW_LEN;
  localparam int CTR_AW      = SLOT_W + MAX_HISTORY;
  localparam int IN_W        = 104;
  localparam int OUT_W       = 104;
  localparam int CFG_DATA_W  = 5;

  // configuration register indexes
  localparam logic [2:0] REG_INDEX_BITS   = 3'd0;
  localparam logic [2:0] REG_HISTORY_BITS = 3'd1;
  localparam logic [2:0] REG_TAG_BITS     = 3'd2;
  localparam logic [2:0] REG_INIT_CTR     = 3'd3;
  localparam logic [2:0] REG_GLOBAL_HIST  = 3'd4;
  localparam logic [2:0] REG_SHARED_ROWS  = 3'd5;
  localparam logic [2:0] REG_XOR_SEL      = 3'd6;

  // share modes
  localparam logic [1:0] SHARE_LOW = 2'd1;
  localparam logic [1:0] SHARE_MID = 2'd2;

  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic [2:0] index_bits;
    logic [3:0] history_bits;
    logic [4:0] tag_bits;
    logic [1:0] initial_counter;
    logic       global_history;
    logic       shared_rows;
    logic [1:0] xor_sel;
  } cfg_t;

  // decoded branch waiting for the back end
  typedef struct packed {
    logic        func;
    logic        taken;
    logic        flush;
    logic [SLOT_W-1:0]      slot;
    logic [MAX_TAG-1:0]     tag;
    logic [MAX_HISTORY-1:0] share;
    logic [31:0] pc_plus4;
    logic [31:0] target;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/bbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/bbp_front.sv -----
// Front end: accepts beats, decodes slot, tag, share bits and flush flag,
// and queues them in a two-entry FIFO. Depends on bbp_pkg.
`default_nettype none
module bbp_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bbp_pkg::cfg_t        cfg,
  input  wire logic                 hold,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [bbp_pkg::IN_W-1:0] s_tdata,
  input  wire logic                 s_tuser,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output bbp_pkg::item_t            q_item
);
  import bbp_pkg::*;

  logic [31:0] pc, target, earlier;
  logic        taken;
  logic [2:0]  ib;
  logic [4:0]  tb;
  logic [SLOT_W-1:0]  smask;
  logic [MAX_TAG-1:0] tmask;
  item_t d;

  item_t      fifo [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign pc      = s_tdata[31:0];
  assign target  = s_tdata[63:32];
  assign taken   = s_tdata[64];
  assign earlier = s_tdata[96:65];

  always_comb begin
    ib = (cfg.index_bits > 3'(SLOT_W)) ? 3'(SLOT_W) : cfg.index_bits;
    tb = (cfg.tag_bits > 5'(MAX_TAG)) ? 5'(MAX_TAG) : cfg.tag_bits;
    smask = ~({SLOT_W{1'b1}} << ib);
    tmask = ~({MAX_TAG{1'b1}} << tb);
    d.func     = s_tuser;
    d.taken    = taken;
    d.pc_plus4 = pc + 32'd4;
    d.target   = target;
    d.flush    = taken ? (earlier != target) : (earlier != d.pc_plus4);
    d.slot     = pc[SLOT_W+1:2] & smask;
    d.tag      = pc[31:2] & tmask;
    case (cfg.xor_sel)
      SHARE_LOW: d.share = pc[MAX_HISTORY+1:2];
      SHARE_MID: d.share = pc[MAX_HISTORY+15:16];
      default:   d.share = '0;
    endcase
  end

  assign s_tready = (count != 2'd2) && !hold;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= d;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/bbp_back.sv -----
// Back end: BTB lookup, counter RAM read-modify-write, row refill and
// clearing sweep, result register. Depends on bbp_pkg and bbp_ram.
`default_nettype none
module bbp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bbp_pkg::cfg_t        cfg,
  input  wire logic                 clear_start,
  output logic                      clearing,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire bbp_pkg::item_t       q_item,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [bbp_pkg::OUT_W-1:0] m_tdata
);
  import bbp_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_LOOKUP  = 5'b00100,
    S_REFILL  = 5'b01000,
    S_RESOLVE = 5'b10000
  } state_t;

  state_t state;
  item_t  cur;
  logic [CTR_AW-1:0] cnt;

  logic               valid [BTB_DEPTH];
  logic [MAX_TAG-1:0] tags  [BTB_DEPTH];
  logic [31:0]        tgts  [BTB_DEPTH];
  logic [MAX_HISTORY-1:0] lhist [BTB_DEPTH];
  logic [MAX_HISTORY-1:0] shist;
  logic [31:0] branches, flushes;

  logic [3:0]  hb;
  logic [MAX_HISTORY-1:0] hmask, h, ci, hnew;
  logic [SLOT_W-1:0] row;
  logic        hit, hit_q;
  logic [CTR_AW-1:0] addr_q;
  logic        we;
  logic [CTR_AW-1:0] waddr, raddr;
  logic [1:0]  wdata, c, c_next;
  logic        out_free;
  logic        out_taken;
  logic [31:0] out_target, out_br, out_fl;

  bbp_ram #(.WIDTH(2), .DEPTH(CTR_DEPTH)) u_ctr (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(c)
  );

  assign clearing = (state == S_CLEAR);
  assign q_ready  = (state == S_IDLE) || (state == S_RESOLVE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {7'd0, out_fl, out_br, out_target, out_taken};

  always_comb begin
    hb    = (cfg.history_bits > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : cfg.history_bits;
    hmask = MAX_HISTORY'(~({(MAX_HISTORY+1){1'b1}} << hb));
    h     = cfg.global_history ? shist : lhist[cur.slot];
    ci    = (h ^ cur.share) & hmask;
    row   = cfg.shared_rows ? '0 : cur.slot;
    hit   = valid[cur.slot] && (tags[cur.slot] == cur.tag);
    raddr = {row, ci};
    hnew  = {h[MAX_HISTORY-2:0], cur.taken} & hmask;
    if (cur.taken) c_next = (c == 2'd3) ? c : c + 2'd1;
    else           c_next = (c == 2'd0) ? c : c - 2'd1;
    we    = 1'b0;
    waddr = addr_q;
    wdata = c_next;
    case (state)
      S_CLEAR: begin
        we = 1'b1; waddr = cnt; wdata = cfg.initial_counter;
      end
      S_REFILL: begin
        we = 1'b1; waddr = {cur.slot, cnt[MAX_HISTORY-1:0]}; wdata = cfg.initial_counter;
      end
      S_RESOLVE: we = (cur.func == FUNC_UPDATE);
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      shist    <= '0;
      branches <= '0;
      flushes  <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < BTB_DEPTH; i++) begin
        valid[i] <= 1'b0;
        lhist[i] <= '0;
      end
    end else begin
      // the result register is always empty in resolve, which loads it
      if (m_tready && state != S_RESOLVE) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (&cnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          addr_q <= raddr;
          hit_q  <= hit;
          if (cur.func == FUNC_UPDATE && !hit) begin
            // install, then look up again once the row is fresh
            valid[cur.slot] <= 1'b1;
            tags[cur.slot]  <= cur.tag;
            if (!cfg.global_history) lhist[cur.slot] <= '0;
            cnt <= '0;
            if (!cfg.shared_rows) state <= S_REFILL;
          end else if (out_free) begin
            state <= S_RESOLVE;
          end
        end
        S_REFILL: begin
          cnt <= cnt + 1'b1;
          if (&cnt[MAX_HISTORY-1:0]) state <= S_LOOKUP;
        end
        S_RESOLVE: begin
          m_tvalid <= 1'b1;
          if (cur.func == FUNC_UPDATE) begin
            if (cfg.global_history) shist <= hnew;
            else lhist[cur.slot] <= hnew;
            tgts[cur.slot] <= cur.target;
            branches   <= branches + 32'd1;
            flushes    <= flushes + 32'(cur.flush);
            out_br     <= branches + 32'd1;
            out_fl     <= flushes + 32'(cur.flush);
            out_taken  <= 1'b0;
            out_target <= '0;
          end else begin
            out_br     <= branches;
            out_fl     <= flushes;
            out_taken  <= hit_q && c[1];
            out_target <= (hit_q && c[1]) ? tgts[cur.slot] : cur.pc_plus4;
          end
          if (q_valid) begin
            cur   <= q_item;
            state <= S_LOOKUP;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_resolve_emits: assert property (@(posedge clk) disable iff (rst || clear_start)
    state == S_RESOLVE |=> m_tvalid) else $error("resolve did not load result");
  a_refill_installs: assert property (@(posedge clk) disable iff (rst || clear_start)
    (state == S_REFILL && &cnt[MAX_HISTORY-1:0]) |=> (state == S_LOOKUP && hit))
    else $error("refill did not leave a hitting entry");
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !q_ready) else $error("queue popped during clear");
`endif
endmodule
`default_nettype wire

// ----- rtl/btb_two_level_branch_predictor.sv -----
// Top level of the two-level branch predictor: configuration registers,
// front end, back end. Depends on bbp_pkg, bbp_front, bbp_back, bbp_ram.
`default_nettype none
// Direct-mapped 32-entry BTB with two-bit counters indexed by global or
// per-entry history, optionally XORed with pc bits (gshare style). Each
// input beat is a predict or an update and gives one result beat. A front
// end decodes beats into a two-entry queue; the back end does BTB lookup
// and counter RAM read, then resolve and write back, popping the next item
// in resolve; a lookup waits while the result register is not free. An update
// that misses in the BTB with per-entry tables refills the entry's
// 256-counter row in the counter RAM, one counter per cycle. After reset,
// and after every write of a defined configuration register, the back
// end's state is cleared and all 8192 counters are swept to the initial
// counter, while no input beat is taken (configuration writes are always
// taken). Predict results carry taken and target; update results carry
// zero there. Both carry the branch and flush counts.
module btb_two_level_branch_predictor (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // pc[31:0], resolved_target[63:32], resolved_taken[64],
  // earlier_prediction[96:65], zero fill
  input  wire logic [bbp_pkg::IN_W-1:0]       s_tdata,
  // func (0 predict, 1 update)
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // predicted_taken[0], predicted_target[32:1], branch_count[64:33],
  // flush_count[96:65], zero fill
  output logic [bbp_pkg::OUT_W-1:0]           m_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [bbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbp_pkg::*;

  cfg_t  cfg;
  logic  cfg_wr, clear_start, clearing;
  logic  q_valid, q_ready;
  item_t q_item;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign clear_start = cfg_wr && (cfg_index <= REG_XOR_SEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_bits      <= 3'd5;
      cfg.history_bits    <= 4'd8;
      cfg.tag_bits        <= 5'd30;
      cfg.initial_counter <= 2'd1;
      cfg.global_history  <= 1'b0;
      cfg.shared_rows     <= 1'b0;
      cfg.xor_sel         <= 2'd0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_INDEX_BITS:   cfg.index_bits      <= cfg_data[2:0];
        REG_HISTORY_BITS: cfg.history_bits    <= cfg_data[3:0];
        REG_TAG_BITS:     cfg.tag_bits        <= cfg_data[4:0];
        REG_INIT_CTR:     cfg.initial_counter <= cfg_data[1:0];
        REG_GLOBAL_HIST:  cfg.global_history  <= cfg_data[0];
        REG_SHARED_ROWS:  cfg.shared_rows     <= cfg_data[0];
        REG_XOR_SEL:      cfg.xor_sel         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  bbp_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .hold(clearing),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  bbp_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .clear_start(clear_start), .clearing(clearing),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for btb_two_level_branch_predictor.
// Depends on bbp_pkg and the RTL. A clocked driver feeds predict and update
// beats from a queue, a clocked monitor checks results against a predictor.
`default_nettype none
module testbench;
  import bbp_pkg::*;

  typedef struct packed {
    logic        func;
    logic [31:0] pc;
    logic [31:0] tgt;
    logic        taken;
    logic [31:0] early;
  } branch_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] target;
    logic [31:0] branches;
    logic [31:0] flushes;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // stream in: pc, resolved target, resolved taken, earlier prediction
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tuser = 1'b0;
  // stream out: taken, target, branch count, flush count
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  // config write channel
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  btb_two_level_branch_predictor uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: its own copy of the settings and of every table
  // ---------------------------------------------------------------------
  cfg_t        p_cfg;
  logic        p_valid  [BTB_DEPTH];
  logic [29:0] p_tag    [BTB_DEPTH];
  logic [31:0] p_target [BTB_DEPTH];
  logic [7:0]  p_hist   [BTB_DEPTH];
  logic [7:0]  p_ghist;
  logic [1:0]  p_ctr    [BTB_DEPTH][ROW_LEN];
  logic [31:0] p_branches, p_flushes;

  branch_t  pending_beats[$];
  verdict_t expected_verdicts[$];

  int  errors = 0;
  int  results_seen = 0;
  int  updates_sent = 0;
  int  refills_seen = 0;
  bit  quiet = 1'b0;       // no idling in the last part of the run
  int  hold_req = 0;       // bumped to ask the receiver for a long hold-off

  task automatic clear_tables();
    for (int i = 0; i < BTB_DEPTH; i++) begin
      p_valid[i] = 1'b0;
      p_tag[i] = '0;
      p_target[i] = '0;
      p_hist[i] = '0;
      for (int j = 0; j < ROW_LEN; j++) p_ctr[i][j] = p_cfg.initial_counter;
    end
    p_ghist = '0;
    p_branches = '0;
    p_flushes = '0;
  endtask

  function automatic logic [7:0] hist_mask();
    int hb;
    hb = (p_cfg.history_bits > MAX_HISTORY) ? MAX_HISTORY : p_cfg.history_bits;
    return 8'((1 << hb) - 1);
  endfunction

  function automatic logic [4:0] slot_for(logic [31:0] pc);
    int ib;
    ib = (p_cfg.index_bits > SLOT_W) ? SLOT_W : p_cfg.index_bits;
    return 5'(pc[6:2] & ((1 << ib) - 1));
  endfunction

  function automatic logic [29:0] tag_for(logic [31:0] pc);
    int tb;
    logic [63:0] m;
    tb = (p_cfg.tag_bits > MAX_TAG) ? MAX_TAG : p_cfg.tag_bits;
    m = (64'd1 << tb) - 1;
    return 30'(pc[31:2] & m[29:0]);
  endfunction

  function automatic logic [7:0] ctr_index(logic [31:0] pc, logic [4:0] slot);
    logic [7:0] h, hm;
    hm = hist_mask();
    h = (p_cfg.global_history ? p_ghist : p_hist[slot]) & hm;
    if (p_cfg.xor_sel == SHARE_LOW) h ^= pc[9:2] & hm;
    else if (p_cfg.xor_sel == SHARE_MID) h ^= pc[23:16] & hm;
    return h & hm;
  endfunction

  task automatic predict_branch(input branch_t b, output verdict_t v);
    logic [4:0] slot, row;
    logic [7:0] ci;
    logic [1:0] c;
    logic hit;
    slot = slot_for(b.pc);
    hit = p_valid[slot] && (p_tag[slot] == tag_for(b.pc));
    v = '0;
    if (b.func != FUNC_UPDATE) begin
      row = p_cfg.shared_rows ? 5'd0 : slot;
      c = p_ctr[row][ctr_index(b.pc, slot)];
      if (hit && c >= 2) begin
        v.taken = 1'b1;
        v.target = p_target[slot];
      end else begin
        v.target = b.pc + 32'd4;
      end
    end else begin
      p_branches++;
      if ((!b.taken && b.early != b.pc + 32'd4) || (b.taken && b.early != b.tgt))
        p_flushes++;
      if (!hit) begin
        if (!p_cfg.shared_rows) begin
          refills_seen++;
          for (int j = 0; j < ROW_LEN; j++) p_ctr[slot][j] = p_cfg.initial_counter;
        end
        if (!p_cfg.global_history) p_hist[slot] = '0;
        p_tag[slot] = tag_for(b.pc);
        p_valid[slot] = 1'b1;
      end
      row = p_cfg.shared_rows ? 5'd0 : slot;
      ci = ctr_index(b.pc, slot);
      c = p_ctr[row][ci];
      if (b.taken) begin
        if (c < 3) c++;
      end else if (c > 0) begin
        c--;
      end
      p_ctr[row][ci] = c;
      if (p_cfg.global_history) p_ghist = ((p_ghist << 1) | b.taken) & hist_mask();
      else p_hist[slot] = ((p_hist[slot] << 1) | b.taken) & hist_mask();
      p_target[slot] = b.tgt;
    end
    v.branches = p_branches;
    v.flushes = p_flushes;
  endtask

  // ---------------------------------------------------------------------
  // Driver: one beat at a time from pending_beats, random idle bursts
  // ---------------------------------------------------------------------
  branch_t on_bus;
  int      tx_gap = 0;

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_branch(on_bus, v);
        expected_verdicts.push_back(v);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          on_bus = pending_beats.pop_front();
          s_tdata <= {7'd0, on_bus.early, on_bus.taken, on_bus.tgt, on_bus.pc};
          s_tuser <= on_bus.func;
          s_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, long hold-off on request, checking
  // ---------------------------------------------------------------------
  int rx_gap = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[32:1], m_tdata[64:33], m_tdata[96:65]};
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.taken !== want.taken || got.target !== want.target ||
              got.branches !== want.branches || got.flushes !== want.flushes) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: taken %b/%b target %h/%h branches %0d/%0d flushes %0d/%0d",
                       want.taken, got.taken, want.target, got.target,
                       want.branches, got.branches, want.flushes, got.flushes);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_beat(input logic f, input logic [31:0] pc, input logic [31:0] tgt,
                           input logic tk, input logic [31:0] early);
    branch_t b;
    b = '{func: f, pc: pc, tgt: tgt, taken: tk, early: early};
    if (f == FUNC_UPDATE) updates_sent++;
    pending_beats.push_back(b);
  endtask

  // wait until the block has drained every result, then a few spare cycles;
  // sampled on the falling edge so that the driver's updates have settled
  task automatic drain();
    while (pending_beats.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
      @(negedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INDEX_BITS:   p_cfg.index_bits = val[2:0];
      REG_HISTORY_BITS: p_cfg.history_bits = val[3:0];
      REG_TAG_BITS:     p_cfg.tag_bits = val[4:0];
      REG_INIT_CTR:     p_cfg.initial_counter = val[1:0];
      REG_GLOBAL_HIST:  p_cfg.global_history = val[0];
      REG_SHARED_ROWS:  p_cfg.shared_rows = val[0];
      REG_XOR_SEL:      p_cfg.xor_sel = val[1:0];
      default: ;
    endcase
    clear_tables();
    @(posedge clk);
  endtask

  task automatic setup(input logic [4:0] ib, input logic [4:0] hb, input logic [4:0] tb,
                       input logic [4:0] ic, input logic [4:0] gh, input logic [4:0] gt,
                       input logic [4:0] sm);
    write_reg(REG_INDEX_BITS, ib);
    write_reg(REG_HISTORY_BITS, hb);
    write_reg(REG_TAG_BITS, tb);
    write_reg(REG_INIT_CTR, ic);
    write_reg(REG_GLOBAL_HIST, gh);
    write_reg(REG_SHARED_ROWS, gt);
    write_reg(REG_XOR_SEL, sm);
  endtask

  // mostly well-formed traffic over a small set of hot branches, some noise
  task automatic random_phase(input int n);
    logic [31:0] pcs[8], tgts[8];
    logic [31:0] pc, tgt, early;
    logic tk, f;
    int k;
    for (int i = 0; i < 8; i++) begin
      pcs[i] = $urandom();
      tgts[i] = $urandom();
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) begin
        pc = $urandom();
        tgt = $urandom();
      end else begin
        pc = pcs[k];
        tgt = ($urandom_range(0, 7) == 0) ? $urandom() : tgts[k];
      end
      f = $urandom_range(0, 1);
      tk = ($urandom_range(0, 3) != 0) ^ k[0];
      case ($urandom_range(0, 3))
        0: early = $urandom();
        1: early = pc + 32'd4;
        default: early = tk ? tgt : pc + 32'd4;
      endcase
      push_beat(f, pc, tgt, tk, early);
    end
  endtask

  initial begin
    p_cfg = '{index_bits: 3'd5, history_bits: 4'd8, tag_bits: 5'd30,
              initial_counter: 2'd1, global_history: 1'b0, shared_rows: 1'b0,
              xor_sel: 2'd0};
    clear_tables();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings
    push_beat(1'b0, 32'h0000_0000, '0, 1'b0, '0);           // empty entry
    push_beat(1'b0, 32'hFFFF_FFFC, '0, 1'b0, '0);           // pc+4 wraps
    push_beat(1'b1, 32'h0000_0100, 32'h0000_2000, 1'b1, 32'h0000_2000);
    push_beat(1'b1, 32'h0000_0100, 32'h0000_2000, 1'b1, 32'hFFFF_FFFF);  // flush
    push_beat(1'b0, 32'h0000_0100, '0, 1'b0, '0);
    push_beat(1'b1, 32'h0000_0100, 32'h0000_2000, 1'b1, 32'h0000_2000);
    push_beat(1'b1, 32'h0000_0100, 32'h0000_2000, 1'b1, 32'h0000_2000);  // taken again
    push_beat(1'b0, 32'h0000_0100, '0, 1'b0, '0);
    push_beat(1'b1, 32'h0000_0100, 32'h0000_3000, 1'b0, 32'h0000_0104);
    push_beat(1'b1, 32'h0000_0100, 32'h0000_3000, 1'b0, 32'h0000_3000);  // flush
    push_beat(1'b1, 32'h0000_0100, 32'h0000_3000, 1'b0, 32'h0000_0104);
    push_beat(1'b1, 32'h0000_0100, 32'h0000_3000, 1'b0, 32'h0000_0104);  // floor
    push_beat(1'b0, 32'h0000_0100, '0, 1'b0, '0);
    push_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_beat(1'b0, 32'hFFFF_FFFF, '0, 1'b1, 32'hFFFF_FFFF);
    push_beat(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0003);  // wrap, no flush
    push_beat(1'b1, 32'h0000_0180, 32'h0000_4000, 1'b1, 32'h0000_4000);  // same slot, new tag
    push_beat(1'b0, 32'h0000_0100, '0, 1'b0, '0);           // evicted
    push_beat(1'b0, 32'h0000_0180, '0, 1'b0, '0);
    drain();

    // every register, typical values; long receiver hold-off mid-phase
    setup(5'd5, 5'd8, 5'd30, 5'd2, 5'd0, 5'd0, 5'd1);
    random_phase(100);
    hold_req++;
    random_phase(300);
    drain();

    // out-of-range extremes, shared history and table, mid-share
    setup(5'd7, 5'd15, 5'd31, 5'd3, 5'd1, 5'd1, 5'd2);
    random_phase(400);
    drain();

    // zero widths, reserved share mode
    setup(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd3);
    random_phase(400);
    drain();

    setup(5'd3, 5'd4, 5'd12, 5'd1, 5'd1, 5'd0, 5'd0);
    random_phase(400);
    drain();

    // last part: no idling on either side
    setup(5'd5, 5'd1, 5'd30, 5'd3, 5'd0, 5'd1, 5'd1);
    quiet = 1'b1;
    random_phase(400);
    drain();

    $display("covered %0d result beats, %0d updates, %0d row refills over six settings",
             results_seen, updates_sent, refills_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

  // run limit: sweeps, refills and stalls several times over
  initial begin
    #50000000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
